>>> hdl/jbce_pkg.sv
// ----------------------------------------------------------------------------
// jbce_pkg
// shared widths, codes and defaults of the block coefficient expander
// ----------------------------------------------------------------------------
package jbce_pkg;

  localparam int NUM_COMPONENTS_DEFAULT = 3;

  localparam int COEF_W = 16;
  localparam int BITS_W = 15;
  localparam int SIZE_W = 4;
  localparam int SYM_W  = 8;
  localparam int COMP_W = 2;
  localparam int POS_W  = 6;

  // item kinds
  localparam logic MODE_DC = 1'b0;
  localparam logic MODE_AC = 1'b1;

  // special ac symbols
  localparam logic [SYM_W-1:0] SYM_EOB = 8'h00;
  localparam logic [SYM_W-1:0] SYM_ZRL = 8'hF0;

  localparam logic [6:0] BLOCK_LEN   = 7'd64;
  localparam logic [6:0] ZRL_LEN     = 7'd16;
  localparam logic [3:0] MAX_DC_CAT  = 4'd15;

endpackage

>>> hdl/jpeg_block_coefficient_expander.sv
// ----------------------------------------------------------------------------
// jpeg_block_coefficient_expander
// expands decoded dc/ac symbols into the 64 zigzag coefficients of a block
// ----------------------------------------------------------------------------
// The block takes one symbol transaction at a time and is not ready while it
// works on it. A DC transaction steps through accept, magnitude decode, then
// predictor add and result. An AC transaction steps through accept and
// magnitude decode and then emits each result it causes (zeros of the run
// plus the coefficient), up to 63 results for an end of block at position
// 1. The single result register sets the pace: one coefficient leaves per
// cycle while the output takes them, and back pressure on the output
// stretches the sequence. An AC transaction with no open block causes no
// result. The shared magnitude decoder serves both the DC difference and
// the AC coefficient.
// ----------------------------------------------------------------------------
module jpeg_block_coefficient_expander #(
  parameter int NUM_COMPONENTS = jbce_pkg::NUM_COMPONENTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic [jbce_pkg::COMP_W-1:0]        component,
  input  logic [jbce_pkg::SYM_W-1:0]         symbol,
  input  logic [jbce_pkg::BITS_W-1:0]        magnitude_bits,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [jbce_pkg::COEF_W-1:0] coefficient,
  output logic [jbce_pkg::POS_W-1:0]         position,
  output logic                               end_of_run,
  output logic                               end_of_block,
  output logic                               error
);
  import jbce_pkg::*;

  // predictor table is sized to a power of two so the index has exactly the
  // bits it needs; entries at or above NUM_COMPONENTS are only cleared at reset and never used
  localparam int PredIdxW  = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int PredDepth = 1 << PredIdxW;
  localparam logic [COMP_W:0] NumComp = (COMP_W+1)'(NUM_COMPONENTS);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIFF  = 2'd1;
  localparam logic [1:0] S_DCSUM = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]          state;
  logic                mode_q;
  logic [COMP_W-1:0]   comp_q;
  logic [SIZE_W-1:0]   size_q;
  logic [BITS_W-1:0]   bits_q;
  logic                err_q;
  logic                coef_follows;
  logic [POS_W-1:0]    zeros_left;
  logic [6:0]          next_pos;
  logic [COEF_W-1:0]   diff;
  logic [COEF_W-1:0]   predictor [PredDepth];

  logic                in_fire;
  logic                out_free;
  logic                load;
  logic                block_open;
  logic [6:0]          room;
  logic [3:0]          run;
  logic [POS_W-1:0]    zeros_start;
  logic                follows_start;
  logic                err_start;
  logic [SIZE_W-1:0]   size_start;
  logic [COEF_W-1:0]   mag_value;
  logic                comp_ok;
  logic [PredIdxW-1:0] pred_idx;
  logic [COEF_W-1:0]   dc_sum;

  // result about to be loaded into the output register
  logic [COEF_W-1:0]   res_coef;
  logic [POS_W-1:0]    res_pos;
  logic                res_eor;
  logic                res_eob;
  logic                res_err;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign load     = out_free && ((state == S_DCSUM) || (state == S_EMIT));

  // a block is open once a dc item has started it and until it is full
  assign block_open = (next_pos != 7'd0) && (next_pos < BLOCK_LEN);
  assign room       = BLOCK_LEN - next_pos;
  assign run        = symbol[7:4];

  // run length of the incoming ac item, clamped to the room left
  always_comb begin
    zeros_start   = '0;
    follows_start = 1'b1;
    err_start     = 1'b0;
    if (symbol == SYM_EOB) begin
      zeros_start   = room[POS_W-1:0];
      follows_start = 1'b0;
    end else if (symbol == SYM_ZRL) begin
      zeros_start   = (room < ZRL_LEN) ? room[POS_W-1:0] : ZRL_LEN[POS_W-1:0];
      follows_start = 1'b0;
    end else begin
      // 0xN0 with N in 1..14: zero coefficient, flagged
      err_start   = (symbol[3:0] == 4'd0);
      zeros_start = ({3'b000, run} >= room) ? 6'(room - 7'd1) : {2'b00, run};
    end
  end

  // dc categories above 15 count as 15
  assign size_start = (mode == MODE_DC) ?
                      ((symbol > {4'd0, MAX_DC_CAT}) ? MAX_DC_CAT : symbol[3:0]) :
                      symbol[3:0];

  jbce_mag u_mag (
    .size  (size_q),
    .bits  (bits_q),
    .value (mag_value)
  );

  assign comp_ok  = ({1'b0, comp_q} < NumComp);
  assign pred_idx = comp_q[PredIdxW-1:0];
  assign dc_sum   = comp_ok ? (diff + predictor[pred_idx]) : diff;

  always_comb begin
    res_coef = '0;
    res_pos  = next_pos[POS_W-1:0];
    res_eor  = 1'b0;
    res_err  = err_q;
    if (state == S_DCSUM) begin
      res_coef = dc_sum;
      res_pos  = '0;
      res_eor  = 1'b1;
      res_err  = 1'b0;
    end else if (zeros_left != '0) begin
      res_eor = (zeros_left == POS_W'(1)) && !coef_follows;
    end else begin
      res_coef = diff;
      res_eor  = 1'b1;
    end
    res_eob = (res_pos == POS_W'(63));
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      next_pos     <= '0;
      zeros_left   <= '0;
      coef_follows <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < PredDepth; i++) begin
        predictor[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (mode == MODE_DC) begin
              state <= S_DIFF;
            end else if (block_open) begin
              state        <= S_DIFF;
              zeros_left   <= zeros_start;
              coef_follows <= follows_start;
            end
          end
        end
        S_DIFF: begin
          state <= (mode_q == MODE_DC) ? S_DCSUM : S_EMIT;
        end
        S_DCSUM: begin
          if (load) begin
            if (comp_ok) begin
              predictor[pred_idx] <= dc_sum;
            end
            next_pos <= 7'd1;
            state    <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (load) begin
            next_pos <= next_pos + 7'd1;
            if (zeros_left != '0) begin
              zeros_left <= zeros_left - POS_W'(1);
            end
            if (res_eor) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item capture, decoded magnitude and output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q <= mode;
      comp_q <= component;
      size_q <= size_start;
      bits_q <= magnitude_bits;
      err_q  <= (mode == MODE_AC) && err_start;
    end
    if (state == S_DIFF) begin
      diff <= mag_value;
    end
    if (load) begin
      coefficient  <= res_coef;
      position     <= res_pos;
      end_of_run   <= res_eor;
      end_of_block <= res_eob;
      error        <= res_err;
    end
  end

  // block position never runs past a full block
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    next_pos <= BLOCK_LEN)
    else $error("next position beyond block");

  // position 63 leaves no room, so it always closes the transaction
  a_eob_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_block |-> end_of_run)
    else $error("end of block without end of run");

  // dc results are never flagged as errors
  a_err_not_dc: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> position != '0)
    else $error("error flag on position zero");

  // the last result of a transaction hands control back
  a_eor_idle: assert property (@(posedge clk) disable iff (rst)
    load && res_eor |=> state == S_IDLE)
    else $error("sequencer busy after last result");

  // an accepted dc transaction moves on to the magnitude decode state
  a_accept_state: assert property (@(posedge clk) disable iff (rst)
    in_fire && (mode == MODE_DC) |=> state == S_DIFF)
    else $error("dc transaction not decoded");

endmodule

>>> hdl/jbce_mag.sv
// ----------------------------------------------------------------------------
// jbce_mag
// turns a size and its appended bits into a signed coefficient value
// ----------------------------------------------------------------------------
module jbce_mag (
  input  logic [jbce_pkg::SIZE_W-1:0] size,
  input  logic [jbce_pkg::BITS_W-1:0] bits,
  output logic [jbce_pkg::COEF_W-1:0] value
);
  import jbce_pkg::*;

  logic [COEF_W-1:0] mask;
  logic [COEF_W-1:0] masked;
  logic              positive;

  always_comb begin
    mask     = (COEF_W'(1) << size) - COEF_W'(1);
    masked   = {1'b0, bits} & mask;
    positive = (size != '0) && masked[size - SIZE_W'(1)];
    if (size == '0) begin
      value = '0;
    end else if (positive) begin
      value = masked;
    end else begin
      // negative: b - (2^m - 1), wraps at 16 bits
      value = masked - mask;
    end
  end

endmodule

>>> bench/jbce_coefficient_checker.sv
// ----------------------------------------------------------------------------
// jbce_coefficient_checker
// watches both channels of the coefficient expander, predicts every
// coefficient from the accepted symbols and compares in order
// ----------------------------------------------------------------------------
module jbce_coefficient_checker #(
  parameter int NUM_COMPONENTS = jbce_pkg::NUM_COMPONENTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               mode,
  input  logic [jbce_pkg::COMP_W-1:0]        component,
  input  logic [jbce_pkg::SYM_W-1:0]         symbol,
  input  logic [jbce_pkg::BITS_W-1:0]        magnitude_bits,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [jbce_pkg::COEF_W-1:0] coefficient,
  input  logic [jbce_pkg::POS_W-1:0]         position,
  input  logic                               end_of_run,
  input  logic                               end_of_block,
  input  logic                               error,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import jbce_pkg::*;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [POS_W-1:0]         pos;
    logic                     last_of_item;
    logic                     last_of_block;
    logic                     bad_symbol;
  } coef_result_t;

  coef_result_t       coef_expected_q[$];
  logic [COEF_W-1:0]  dc_pred[NUM_COMPONENTS];
  int                 next_pos;

  // category/size plus raw bits to a two's complement value
  function automatic logic [COEF_W-1:0] decode_magnitude(logic [SIZE_W-1:0] size,
                                                         logic [BITS_W-1:0] bits);
    logic [COEF_W-1:0] mask;
    logic [COEF_W-1:0] b;
    if (size == '0) return '0;
    mask = (16'd1 << size) - 16'd1;
    b = {1'b0, bits} & mask;
    if (b[size - 1]) return b;
    return b - mask;
  endfunction

  function automatic void push_result(logic [COEF_W-1:0] c, int p, logic eor, logic bad);
    coef_result_t r;
    r.coef          = c;
    r.pos           = POS_W'(p);
    r.last_of_item  = eor;
    r.last_of_block = (p == 63);
    r.bad_symbol    = bad;
    coef_expected_q.push_back(r);
  endfunction

  function automatic void expand_symbol(logic m, logic [COMP_W-1:0] comp,
                                        logic [SYM_W-1:0] sym, logic [BITS_W-1:0] bits);
    logic [COEF_W-1:0] sum;
    logic [SIZE_W-1:0] cat;
    int                room;
    int                run_len;
    int                zeros;
    int                total;
    logic              bad;
    logic              coef_follows;
    if (m == MODE_DC) begin
      cat = (sym > MAX_DC_CAT) ? MAX_DC_CAT : sym[SIZE_W-1:0];
      sum = decode_magnitude(cat, bits);
      if (int'(comp) < NUM_COMPONENTS) begin
        sum = sum + dc_pred[comp];
        dc_pred[comp] = sum;
      end
      push_result(sum, 0, 1'b1, 1'b0);
      next_pos = 1;
      return;
    end
    // no open block: symbol dropped
    if (next_pos == 0 || next_pos >= int'(BLOCK_LEN)) return;
    room    = int'(BLOCK_LEN) - next_pos;
    run_len = int'(sym[7:4]);
    bad     = 1'b0;
    if (sym == SYM_EOB) begin
      zeros        = room;
      coef_follows = 1'b0;
    end else if (sym == SYM_ZRL) begin
      zeros        = (room < int'(ZRL_LEN)) ? room : int'(ZRL_LEN);
      coef_follows = 1'b0;
    end else begin
      bad          = (sym[3:0] == 4'h0);
      zeros        = (run_len >= room) ? room - 1 : run_len;
      coef_follows = 1'b1;
    end
    total = zeros + int'(coef_follows);
    for (int i = 0; i < total; i++) begin
      push_result((i == zeros) ? decode_magnitude(sym[3:0], bits) : '0,
                  next_pos + i, i == total - 1, bad);
    end
    next_pos += total;
  endfunction

  function automatic void check_result();
    coef_result_t want;
    coef_result_t got;
    got.coef          = coefficient;
    got.pos           = position;
    got.last_of_item  = end_of_run;
    got.last_of_block = end_of_block;
    got.bad_symbol    = error;
    if (coef_expected_q.size() == 0) begin
      $display("%0t: unexpected coefficient %0d at position %0d", $time, got.coef, got.pos);
      fail_count++;
      return;
    end
    want = coef_expected_q.pop_front();
    if (got != want) begin
      $display("%0t: mismatch, expected coef=%0d pos=%0d eor=%0b eob=%0b err=%0b",
               $time, want.coef, want.pos, want.last_of_item, want.last_of_block,
               want.bad_symbol);
      $display("%0t:           actual coef=%0d pos=%0d eor=%0b eob=%0b err=%0b",
               $time, got.coef, got.pos, got.last_of_item, got.last_of_block,
               got.bad_symbol);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) dc_pred[i] = '0;
      next_pos = 0;
      coef_expected_q.delete();
      fail_count = 0;
    end else begin
      // results first: a symbol taken at this edge cannot have results out yet
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) expand_symbol(mode, component, symbol, magnitude_bits);
    end
    pending = coef_expected_q.size();
  end

endmodule

>>> bench/jpeg_block_coefficient_expander_tb.sv
// ----------------------------------------------------------------------------
// jpeg_block_coefficient_expander_tb
// drives dc and ac symbols into the coefficient expander under random
// idling on both sides; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module jpeg_block_coefficient_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jbce_pkg::*;

  // cycles without any transaction before the run is declared hung;
  // the longest quiet stretch is an end of block fill under heavy stall
  localparam int QUIET_LIMIT = 4000;
  // drain time after the last expected coefficient: a full block fill
  localparam int DRAIN_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 30;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      mode;
  logic [COMP_W-1:0]         component;
  logic [SYM_W-1:0]          symbol;
  logic [BITS_W-1:0]         magnitude_bits;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [COEF_W-1:0]  coefficient;
  logic [POS_W-1:0]          position;
  logic                      end_of_run;
  logic                      end_of_block;
  logic                      error;

  int fail_count;
  int pending;
  int quiet_cycles;

  // idle rates in percent, changed per phase
  int send_idle_pct;
  int recv_idle_pct;

  // rough block position, only to shape stimulus and count useful items
  int block_pos;
  int active_items;

  jpeg_block_coefficient_expander i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .component      (component),
    .symbol         (symbol),
    .magnitude_bits (magnitude_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .coefficient    (coefficient),
    .position       (position),
    .end_of_run     (end_of_run),
    .end_of_block   (end_of_block),
    .error          (error)
  );

  jbce_coefficient_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .component      (component),
    .symbol         (symbol),
    .magnitude_bits (magnitude_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .coefficient    (coefficient),
    .position       (position),
    .end_of_run     (end_of_run),
    .end_of_block   (end_of_block),
    .error          (error),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls at random, decided at the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: any transaction on either side clears the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one symbol transaction; called and returns at a falling edge
  task automatic send_symbol(input logic m, input logic [COMP_W-1:0] comp,
                             input logic [SYM_W-1:0] sym, input logic [BITS_W-1:0] bits);
    int room;
    // random gap before the transaction, valid low meanwhile
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    component      <= comp;
    symbol         <= sym;
    magnitude_bits <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    // track the open block so ignored ac symbols are not counted
    if (m == MODE_DC) begin
      block_pos = 1;
      active_items++;
    end else if (block_pos >= 1 && block_pos < int'(BLOCK_LEN)) begin
      active_items++;
      room = int'(BLOCK_LEN) - block_pos;
      if (sym == SYM_EOB) begin
        block_pos = int'(BLOCK_LEN);
      end else if (sym == SYM_ZRL) begin
        block_pos += (room < int'(ZRL_LEN)) ? room : int'(ZRL_LEN);
      end else begin
        block_pos += (int'(sym[7:4]) >= room) ? room : int'(sym[7:4]) + 1;
      end
    end
  endtask

  // ac symbol mix: mostly short runs with real sizes, plus the special codes
  function automatic logic [SYM_W-1:0] pick_ac_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 55) return {4'($urandom_range(3)), 4'($urandom_range(15, 1))};
    if (r < 65) return {4'($urandom_range(15, 4)), 4'($urandom_range(15, 1))};
    if (r < 73) return SYM_ZRL;
    // invalid run/size with size zero, flags error but the block goes on
    if (r < 78) return {4'($urandom_range(14, 1)), 4'h0};
    if (r < 88) return SYM_EOB;
    return SYM_W'($urandom_range(255));
  endfunction

  // one block: dc, then ac symbols until full, eob, or a cut-off
  task automatic random_block();
    logic [COMP_W-1:0] comp;
    logic [SYM_W-1:0]  sym;
    logic              done;
    // component 3 is out of range: no predictor touched
    comp = ($urandom_range(9) == 0) ? 2'd3 : COMP_W'($urandom_range(2));
    // dc category mostly legal, sometimes any symbol value
    sym  = ($urandom_range(9) == 0) ? SYM_W'($urandom_range(255))
                                    : SYM_W'($urandom_range(11));
    send_symbol(MODE_DC, comp, sym, BITS_W'($urandom_range(32767)));
    done = 1'b0;
    while (!done && block_pos < int'(BLOCK_LEN)) begin
      sym = pick_ac_symbol();
      send_symbol(MODE_AC, COMP_W'($urandom_range(3)), sym,
                  BITS_W'($urandom_range(32767)));
      // eob closes; an early stop leaves the next dc landing mid-block
      done = (sym == SYM_EOB) || ($urandom_range(19) == 0);
    end
    // occasional stray ac symbol, dropped when the block is closed
    if ($urandom_range(5) == 0) begin
      send_symbol(MODE_AC, COMP_W'($urandom_range(3)), pick_ac_symbol(),
                  BITS_W'($urandom_range(32767)));
    end
  endtask

  initial begin
    int target;
    rst            = 1'b1;
    in_valid       = 1'b0;
    mode           = MODE_DC;
    component      = '0;
    symbol         = '0;
    magnitude_bits = '0;
    out_ready      = 1'b0;
    quiet_cycles   = 0;
    block_pos      = 0;
    active_items   = 0;
    send_idle_pct  = 33;
    recv_idle_pct  = 54;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ac with no block open yet is dropped
    send_symbol(MODE_AC, 2'd0, 8'h11, 15'h0001);
    // dc category zero, then category 11
    send_symbol(MODE_DC, 2'd0, 8'd0, 15'h7FFF);
    send_symbol(MODE_DC, 2'd0, 8'd11, 15'h07FF);
    // size 15 extremes and size 1 negative
    send_symbol(MODE_AC, 2'd0, 8'h0F, 15'h7FFF);
    send_symbol(MODE_AC, 2'd0, 8'h01, 15'h0000);
    send_symbol(MODE_AC, 2'd0, 8'h0F, 15'h0000);
    // zrl, invalid code, long run, invalid code with run 14
    send_symbol(MODE_AC, 2'd0, SYM_ZRL, 15'h0000);
    send_symbol(MODE_AC, 2'd0, 8'h50, 15'h1234);
    send_symbol(MODE_AC, 2'd0, 8'hFA, 15'h02AA);
    send_symbol(MODE_AC, 2'd0, 8'hE0, 15'h7FFF);
    // zrl with only 7 positions left: clamped, block full
    send_symbol(MODE_AC, 2'd0, SYM_ZRL, 15'h0000);
    // block complete: ac dropped
    send_symbol(MODE_AC, 2'd1, 8'h11, 15'h0001);
    // dc category above 15 acts as 15
    send_symbol(MODE_DC, 2'd1, 8'hFF, 15'h4000);
    // component out of range
    send_symbol(MODE_DC, 2'd3, 8'd5, 15'h0000);
    send_symbol(MODE_DC, 2'd2, 8'd15, 15'h0000);
    send_symbol(MODE_AC, 2'd2, 8'h3C, 15'h0ABC);
    // dc mid-block, predictor wraps past 16 bits
    send_symbol(MODE_DC, 2'd2, 8'd15, 15'h0000);
    send_symbol(MODE_AC, 2'd2, SYM_ZRL, 15'h0000);
    send_symbol(MODE_AC, 2'd2, SYM_ZRL, 15'h0000);
    send_symbol(MODE_AC, 2'd2, SYM_ZRL, 15'h0000);
    // run too long for the room left: coefficient lands on position 63
    send_symbol(MODE_AC, 2'd2, 8'hF3, 15'h0005);
    // eob right after dc fills the whole block
    send_symbol(MODE_DC, 2'd0, 8'd1, 15'h0001);
    send_symbol(MODE_AC, 2'd0, SYM_EOB, 15'h0000);
    send_symbol(MODE_DC, 2'd0, 8'd11, 15'h0000);

    // random blocks in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target = active_items + ITEMS_PER_PHASE;
      while (active_items < target) random_block();
    end
    in_valid <= 1'b0;

    // wait for every predicted coefficient, then let a trailing fill drain
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/jbce_pkg.sv
hdl/jbce_mag.sv
hdl/jpeg_block_coefficient_expander.sv
bench/jbce_coefficient_checker.sv
bench/jpeg_block_coefficient_expander_tb.sv
